// ----- rtl/tgr_pkg.sv -----
// Shared constants, codes and command types for the trilinear grid resampler.
`default_nettype none

package tgr_pkg;

  // Grid geometry and number formats.
  localparam int GRID_DIM   = 32;
  localparam int FRAC_W     = 16;
  localparam int VALUE_W    = 32;
  localparam int AXIS_W     = $clog2(GRID_DIM);
  localparam int ADDR_W     = 3 * AXIS_W;
  localparam int DEPTH      = GRID_DIM * GRID_DIM * GRID_DIM;

  // Field and register widths.
  localparam int DEST_W     = 8;
  localparam int SCALE_W    = 22;
  localparam int SIZE_W     = 6;
  localparam int POS_W      = DEST_W + SCALE_W;
  localparam int CELL_W     = POS_W - FRAC_W;
  localparam int CIDX_W     = CELL_W + 1;
  localparam int CORNERS    = 8;
  localparam int CORNER_W   = 3;
  localparam int QCNT_W     = 4;
  localparam int PROD_W     = VALUE_W + FRAC_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Item operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;

  // Axis whose fraction feeds a blend.
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                capture;
    logic                coord;
    logic                fetch;
    logic [CORNER_W-1:0] corner;
    logic                blend;
    logic                last;
    axis_t               axis;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tgr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tgr_datapath.sv -----
// Datapath: grid memory, coordinate multipliers, corner queue and blend pipeline.
`default_nettype none

module tgr_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire tgr_pkg::cmd_t                         cmd,
  input  wire logic        [tgr_pkg::AXIS_W-1:0]     load_x,
  input  wire logic        [tgr_pkg::AXIS_W-1:0]     load_y,
  input  wire logic        [tgr_pkg::AXIS_W-1:0]     load_z,
  input  wire logic signed [tgr_pkg::VALUE_W-1:0]    load_value,
  input  wire logic        [tgr_pkg::DEST_W-1:0]     dest_x,
  input  wire logic        [tgr_pkg::DEST_W-1:0]     dest_y,
  input  wire logic        [tgr_pkg::DEST_W-1:0]     dest_z,
  input  wire logic        [tgr_pkg::SIZE_W-1:0]     size_x,
  input  wire logic        [tgr_pkg::SIZE_W-1:0]     size_y,
  input  wire logic        [tgr_pkg::SIZE_W-1:0]     size_z,
  input  wire logic        [tgr_pkg::SCALE_W-1:0]    scale_x,
  input  wire logic        [tgr_pkg::SCALE_W-1:0]    scale_y,
  input  wire logic        [tgr_pkg::SCALE_W-1:0]    scale_z,
  output logic                                       out_valid,
  output logic signed      [tgr_pkg::VALUE_W-1:0]    out_value
);

  localparam int SIZE_W   = tgr_pkg::SIZE_W;
  localparam int CIDX_W   = tgr_pkg::CIDX_W;
  localparam int QCNT_W   = tgr_pkg::QCNT_W;
  localparam int VALUE_W  = tgr_pkg::VALUE_W;
  localparam int FRAC_W   = tgr_pkg::FRAC_W;
  localparam int AXIS_W   = tgr_pkg::AXIS_W;
  localparam int CORNER_W = tgr_pkg::CORNER_W;

  // Extent clipped to the grid dimension.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return (s > SIZE_W'(tgr_pkg::GRID_DIM)) ? SIZE_W'(tgr_pkg::GRID_DIM) : s;
  endfunction

  logic [tgr_pkg::DEST_W-1:0] dx_r, dy_r, dz_r;
  logic [tgr_pkg::POS_W-1:0]  px, py, pz;
  logic [tgr_pkg::CELL_W-1:0] ix_r, iy_r, iz_r;
  logic [FRAC_W-1:0]          tx_r, ty_r, tz_r;

  logic [CIDX_W-1:0]          cx, cy, cz;
  logic                       in_range;
  logic                       rd_en;
  logic [tgr_pkg::ADDR_W-1:0] rd_addr;
  logic [VALUE_W-1:0]         rd_data;
  logic                       pend_r, pend_in_r;
  logic signed [VALUE_W-1:0]  fetch_val;

  logic signed [VALUE_W-1:0]        c0, c1;
  logic        [FRAC_W-1:0]         t_sel;
  logic signed [VALUE_W:0]          diff;
  logic signed [tgr_pkg::PROD_W-1:0] prod, prod_r;
  logic signed [VALUE_W-1:0]        c0_r;
  logic                             pv_r, last_r;
  logic signed [VALUE_W-1:0]        sum;

  logic signed [VALUE_W-1:0] q_r   [tgr_pkg::CORNERS];
  logic signed [VALUE_W-1:0] q_nxt [tgr_pkg::CORNERS];
  logic [QCNT_W-1:0]         q_cnt_r, q_cnt_nxt, q_pos;
  logic                      push;
  logic signed [VALUE_W-1:0] push_val;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;

  // Destination index is held for the whole query.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx_r <= dest_x;
      dy_r <= dest_y;
      dz_r <= dest_z;
    end
  end

  // Source coordinate per axis: cell in the high bits, fraction in the low bits.
  assign px = tgr_pkg::POS_W'(dx_r) * tgr_pkg::POS_W'(scale_x);
  assign py = tgr_pkg::POS_W'(dy_r) * tgr_pkg::POS_W'(scale_y);
  assign pz = tgr_pkg::POS_W'(dz_r) * tgr_pkg::POS_W'(scale_z);

  always_ff @(posedge clk) begin
    if (cmd.coord) begin
      ix_r <= px[tgr_pkg::POS_W-1:FRAC_W];
      iy_r <= py[tgr_pkg::POS_W-1:FRAC_W];
      iz_r <= pz[tgr_pkg::POS_W-1:FRAC_W];
      tx_r <= px[FRAC_W-1:0];
      ty_r <= py[FRAC_W-1:0];
      tz_r <= pz[FRAC_W-1:0];
    end
  end

  // Corner position and range check; out-of-range corners skip the read.
  assign cx = CIDX_W'(ix_r) + CIDX_W'(cmd.corner[0]);
  assign cy = CIDX_W'(iy_r) + CIDX_W'(cmd.corner[1]);
  assign cz = CIDX_W'(iz_r) + CIDX_W'(cmd.corner[2]);
  assign in_range = (cx < CIDX_W'(eff_size(size_x))) &&
                    (cy < CIDX_W'(eff_size(size_y))) &&
                    (cz < CIDX_W'(eff_size(size_z)));
  assign rd_en   = cmd.fetch & in_range;
  assign rd_addr = {cx[AXIS_W-1:0], cy[AXIS_W-1:0], cz[AXIS_W-1:0]};

  tgr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (tgr_pkg::DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (cmd.load),
    .waddr ({load_x, load_y, load_z}),
    .wdata (load_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Track which read returns next cycle and whether it was in range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.fetch;
    end
    pend_in_r <= in_range;
  end

  assign fetch_val = pend_in_r ? $signed(rd_data) : '0;

  // Blend multiply stage: the two queue heads and the selected fraction.
  assign c0 = q_r[0];
  assign c1 = q_r[1];

  always_comb begin
    case (cmd.axis)
      tgr_pkg::AX_X: t_sel = tx_r;
      tgr_pkg::AX_Y: t_sel = ty_r;
      tgr_pkg::AX_Z: t_sel = tz_r;
      default:       t_sel = '0;
    endcase
  end

  assign diff = $signed({c1[VALUE_W-1], c1}) - $signed({c0[VALUE_W-1], c0});
  assign prod = diff * $signed({1'b0, t_sel});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      last_r <= 1'b0;
    end else begin
      pv_r   <= cmd.blend;
      last_r <= cmd.blend & cmd.last;
    end
    if (cmd.blend) begin
      prod_r <= prod;
      c0_r   <= c0;
    end
  end

  // Add stage: c0 plus the product floored by the fraction width.
  assign sum = c0_r + $signed(prod_r[FRAC_W +: VALUE_W]);

  // Corner queue: blends pop two heads, fetches and blend results push at the tail.
  assign push     = pend_r | (pv_r & ~last_r);
  assign push_val = pend_r ? fetch_val : sum;

  always_comb begin
    q_nxt = q_r;
    if (cmd.blend) begin
      for (int i = 0; i < tgr_pkg::CORNERS - 2; i++) begin
        q_nxt[i] = q_r[i+2];
      end
    end
    q_pos = q_cnt_r - (cmd.blend ? QCNT_W'(2) : QCNT_W'(0));
    if (push) begin
      q_nxt[q_pos[CORNER_W-1:0]] = push_val;
    end
    q_cnt_nxt = q_pos + (push ? QCNT_W'(1) : QCNT_W'(0));
    if (cmd.capture) begin
      q_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
    q_r <= q_nxt;
  end

  // Final blend lands in the output register for a one-cycle strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pv_r & last_r;
    end
    if (pv_r & last_r) begin
      out_value_r <= sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

`default_nettype wire

// ----- rtl/tgr_ctrl.sv -----
// Controller: sequences coordinate, corner fetch and blend steps of a query.
`default_nettype none

module tgr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          op,
  output logic               busy,
  output tgr_pkg::cmd_t      cmd
);

  localparam int CORNER_W = tgr_pkg::CORNER_W;
  // Blend slot that waits for a y result before the z blend.
  localparam logic [CORNER_W-1:0] STEP_WAIT = 3'd6;
  localparam logic [CORNER_W-1:0] STEP_LAST = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_COORD  = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_BLEND  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CORNER_W-1:0] cnt_r, cnt_nxt;
  logic                accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && (op == tgr_pkg::OP_QUERY)) begin
          state_nxt = ST_COORD;
        end
      end
      ST_COORD: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cnt_nxt = cnt_r + CORNER_W'(1);
        if (cnt_r == STEP_LAST) begin
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        cnt_nxt = cnt_r + CORNER_W'(1);
        if (cnt_r == STEP_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Commands: four x blends, two y blends, a wait slot, then the z blend.
  always_comb begin
    cmd         = '0;
    cmd.load    = accept && (op == tgr_pkg::OP_LOAD);
    cmd.capture = accept && (op == tgr_pkg::OP_QUERY);
    cmd.coord   = (state_r == ST_COORD);
    cmd.fetch   = (state_r == ST_FETCH);
    cmd.corner  = cnt_r;
    cmd.blend   = (state_r == ST_BLEND) && (cnt_r != STEP_WAIT);
    cmd.last    = (cnt_r == STEP_LAST);
    if (cnt_r inside {[3'd0:3'd3]}) begin
      cmd.axis = tgr_pkg::AX_X;
    end else if (cnt_r inside {3'd4, 3'd5}) begin
      cmd.axis = tgr_pkg::AX_Y;
    end else begin
      cmd.axis = tgr_pkg::AX_Z;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/trilinear_grid_resample.sv -----
// Top level of the trilinear grid resampler: configuration registers and submodules.
//
//   Channel  Ports                                        Handshake
//   input    start, busy, in_*                            taken when start high and busy low
//   result   out_valid, out_interp_value                  one-cycle strobe, no back-pressure
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data    written when valid and ready high
//
// A load item writes the grid at the edge that takes it, and busy stays low, so loads may
// follow every cycle. A query holds busy through a coordinate step for the multipliers,
// eight corner reads on the grid memory's single read port, eight blend slots on the shared
// multiplier and a finish step for the last add. The result strobes in the first cycle with
// busy low again, when the next item may be taken. Reset is synchronous, clears control state
// and sets configuration defaults; the receiver cannot stall results, and cfg_ready is high.
`default_nettype none

module trilinear_grid_resample (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    in_op,
  input  wire logic        [tgr_pkg::AXIS_W-1:0]       in_load_x,
  input  wire logic        [tgr_pkg::AXIS_W-1:0]       in_load_y,
  input  wire logic        [tgr_pkg::AXIS_W-1:0]       in_load_z,
  input  wire logic signed [tgr_pkg::VALUE_W-1:0]      in_load_value,
  input  wire logic        [tgr_pkg::DEST_W-1:0]       in_dest_x,
  input  wire logic        [tgr_pkg::DEST_W-1:0]       in_dest_y,
  input  wire logic        [tgr_pkg::DEST_W-1:0]       in_dest_z,
  output logic                                         out_valid,
  output logic signed      [tgr_pkg::VALUE_W-1:0]      out_interp_value,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic        [tgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic        [tgr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SIZE_W  = tgr_pkg::SIZE_W;
  localparam int SCALE_W = tgr_pkg::SCALE_W;

  logic [SIZE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [SIZE_W-1:0]  size_x_nxt, size_y_nxt, size_z_nxt;
  logic [SCALE_W-1:0] scale_x_r, scale_y_r, scale_z_r;
  logic [SCALE_W-1:0] scale_x_nxt, scale_y_nxt, scale_z_nxt;
  tgr_pkg::cmd_t      cmd;

  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped.
  always_comb begin
    size_x_nxt  = size_x_r;
    size_y_nxt  = size_y_r;
    size_z_nxt  = size_z_r;
    scale_x_nxt = scale_x_r;
    scale_y_nxt = scale_y_r;
    scale_z_nxt = scale_z_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tgr_pkg::CFG_SIZE_X:  size_x_nxt  = cfg_data[SIZE_W-1:0];
        tgr_pkg::CFG_SIZE_Y:  size_y_nxt  = cfg_data[SIZE_W-1:0];
        tgr_pkg::CFG_SIZE_Z:  size_z_nxt  = cfg_data[SIZE_W-1:0];
        tgr_pkg::CFG_SCALE_X: scale_x_nxt = cfg_data[SCALE_W-1:0];
        tgr_pkg::CFG_SCALE_Y: scale_y_nxt = cfg_data[SCALE_W-1:0];
        tgr_pkg::CFG_SCALE_Z: scale_z_nxt = cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Full 32-cell extent and unit scale out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r  <= SIZE_W'(32);
      size_y_r  <= SIZE_W'(32);
      size_z_r  <= SIZE_W'(32);
      scale_x_r <= SCALE_W'(65536);
      scale_y_r <= SCALE_W'(65536);
      scale_z_r <= SCALE_W'(65536);
    end else begin
      size_x_r  <= size_x_nxt;
      size_y_r  <= size_y_nxt;
      size_z_r  <= size_z_nxt;
      scale_x_r <= scale_x_nxt;
      scale_y_r <= scale_y_nxt;
      scale_z_r <= scale_z_nxt;
    end
  end

  tgr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .busy  (busy),
    .cmd   (cmd)
  );

  tgr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .load_x     (in_load_x),
    .load_y     (in_load_y),
    .load_z     (in_load_z),
    .load_value (in_load_value),
    .dest_x     (in_dest_x),
    .dest_y     (in_dest_y),
    .dest_z     (in_dest_z),
    .size_x     (size_x_r),
    .size_y     (size_y_r),
    .size_z     (size_z_r),
    .scale_x    (scale_x_r),
    .scale_y    (scale_y_r),
    .scale_z    (scale_z_r),
    .out_valid  (out_valid),
    .out_value  (out_interp_value)
  );

endmodule

`default_nettype wire

// ----- rtl/tgr_checker.sv -----
// Port-level checks for the trilinear grid resampler and their bind to the top level.
`default_nettype none

module tgr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_op,
  input wire logic out_valid
);

  // A query item occupies the block from the next cycle on.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == tgr_pkg::OP_QUERY)) |=> busy)
    else $error("query item taken but block not busy");

  // A load item finishes in the cycle it is taken.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == tgr_pkg::OP_LOAD)) |=> !busy)
    else $error("load item left the block busy");

  // Each query yields one strobe, never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A result only follows a busy period.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding query");

endmodule

bind trilinear_grid_resample tgr_checker u_tgr_checker (.*);

`default_nettype wire
